### rtl/sbu_pkg.sv
// ----------------------------------------------------------------------------
// sbu_pkg
// shared widths, reset values, state types and the result bundle of the
// bit-serial arithmetic unit of the spectrum bar updater
// ----------------------------------------------------------------------------
package sbu_pkg;

  localparam int NUM_BINS_DEF = 1024;

  localparam int DIM_W  = 12;
  localparam int BIN_W  = 10;
  localparam int PWR_W  = 32;
  localparam int COL_W  = 8;
  localparam int QUO_W  = 13;
  localparam int PROD_W = PWR_W + DIM_W;
  localparam int XACC_W = BIN_W + DIM_W;
  localparam int CNT_W  = 4;

  localparam logic [DIM_W-1:0] SW_RESET    = 12'd640;
  localparam logic [DIM_W-1:0] SH_RESET    = 12'd480;
  localparam logic [COL_W-1:0] COLOR_WHITE = 8'd255;
  localparam logic [COL_W-1:0] COLOR_BLACK = 8'd0;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_MUL,
    AR_MID,
    AR_DIV,
    AR_FIN
  } ar_state_t;

  typedef struct packed {
    logic             done;
    logic             cut;
    logic [DIM_W-1:0] bh;
    logic [DIM_W-1:0] xs;
    logic [DIM_W-1:0] xe;
  } arith_res_t;

endpackage

### rtl/sbu_arith.sv
// ----------------------------------------------------------------------------
// sbu_arith
// bit-serial arithmetic for one draw word: bar width by restoring division,
// power times height by shift-add, scaling by the running maximum through a
// restoring divider and the bar's column span by shift-add
// ----------------------------------------------------------------------------
module sbu_arith #(
  parameter int NUM_BINS = sbu_pkg::NUM_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sbu_pkg::BIN_W-1:0]   bin,
  input  logic [sbu_pkg::PWR_W-1:0]   pw,
  input  logic [sbu_pkg::PWR_W-1:0]   pmax,
  input  logic [sbu_pkg::DIM_W-1:0]   hgt,
  input  logic [sbu_pkg::DIM_W-1:0]   swid,
  output sbu_pkg::arith_res_t         res
);
  import sbu_pkg::*;

  localparam int RW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [RW:0]      NB      = (RW+1)'(NUM_BINS);
  localparam logic [CNT_W-1:0] MUL_END = CNT_W'(DIM_W - 1);
  localparam logic [CNT_W-1:0] DIV_END = CNT_W'(QUO_W - 1);

  ar_state_t state, state_next;
  logic [CNT_W-1:0] cnt;

  logic [DIM_W-1:0]  hsh;
  logic [DIM_W-1:0]  wsh;
  logic [PROD_W-1:0] prod;
  logic [RW-1:0]     wrem;
  logic [DIM_W-1:0]  bwq;
  logic [DIM_W-1:0]  bw;
  logic [DIM_W:0]    bsh;
  logic [XACC_W-1:0] xacc;
  logic [PWR_W-1:0]  rem;
  logic [QUO_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic              over;

  logic [RW:0]       wtrial;
  logic              wfit;
  logic [PWR_W:0]    dtrial;
  logic              dfit;
  logic [DIM_W-1:0]  bw_eff;
  logic [XACC_W:0]   xe_full;

  assign wtrial  = {wrem, wsh[DIM_W-1]};
  assign wfit    = (wtrial >= NB);
  assign dtrial  = {rem, dsh[QUO_W-1]};
  assign dfit    = (dtrial >= {1'b0, pmax});
  assign bw_eff  = (bwq == '0) ? DIM_W'(1) : bwq;
  assign xe_full = {1'b0, xacc} + (XACC_W+1)'(bw);

  always_comb begin
    state_next = state;
    case (state)
      AR_IDLE: if (start) state_next = AR_MUL;
      AR_MUL:  if (cnt == MUL_END) state_next = AR_MID;
      AR_MID:  state_next = AR_DIV;
      AR_DIV:  if (cnt == DIV_END) state_next = AR_FIN;
      AR_FIN:  state_next = AR_IDLE;
      default: state_next = AR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= AR_IDLE;
      cnt      <= '0;
    end else begin
      state    <= state_next;
      if (state == AR_MUL || state == AR_DIV) begin
        cnt <= (state_next != state) ? '0 : cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res.done <= 1'b0;
    else     res.done <= (state == AR_FIN);
    case (state)
      AR_IDLE: begin
        hsh  <= hgt;
        wsh  <= swid;
        prod <= '0;
        wrem <= '0;
        bwq  <= '0;
      end
      AR_MUL: begin
        // power times height, height msb first
        prod <= {prod[PROD_W-2:0], 1'b0} + (hsh[DIM_W-1] ? PROD_W'(pw) : '0);
        hsh  <= {hsh[DIM_W-2:0], 1'b0};
        // screen width over bin count
        wrem <= wfit ? RW'(wtrial - NB) : RW'(wtrial);
        bwq  <= {bwq[DIM_W-2:0], wfit};
        wsh  <= {wsh[DIM_W-2:0], 1'b0};
      end
      AR_MID: begin
        bw   <= bw_eff;
        bsh  <= {1'b0, bw_eff};
        xacc <= '0;
        rem  <= PWR_W'(prod[PROD_W-1:QUO_W]);
        over <= ({1'b0, prod[PROD_W-1:QUO_W]} >= pmax);
        dsh  <= prod[QUO_W-1:0];
        quo  <= '0;
      end
      AR_DIV: begin
        rem  <= dfit ? PWR_W'(dtrial - {1'b0, pmax}) : PWR_W'(dtrial);
        quo  <= {quo[QUO_W-2:0], dfit};
        dsh  <= {dsh[QUO_W-2:0], 1'b0};
        xacc <= {xacc[XACC_W-2:0], 1'b0} + (bsh[DIM_W] ? XACC_W'(bin) : '0);
        bsh  <= {bsh[DIM_W-1:0], 1'b0};
      end
      AR_FIN: begin
        res.cut <= (xe_full >= (XACC_W+1)'(swid));
        res.bh  <= (over || quo > {1'b0, hgt}) ? hgt : quo[DIM_W-1:0];
        res.xs  <= xacc[DIM_W-1:0];
        res.xe  <= xe_full[DIM_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

### rtl/spectrum_bar_updater.sv
// ----------------------------------------------------------------------------
// spectrum_bar_updater
// incremental spectrum bar renderer: load words store bin power and track the
// running maximum, draw words turn a bin's power into one update rectangle
//
//   channel   direction  handshake          payload
//   input     in         in_valid/in_stall  opcode, bin_index, power_value
//   output    out        out_valid/out_stall rect_x_*, rect_y_*, fill_color
//   config    in         apb write/read     screen_width, screen_height
//
// a load word or an out-of-range bin is taken without leaving idle; a draw
// word holds in_stall high through the 12-step multiply and 13-step divide
// of the serial unit and yields no rectangle if the bar hits the right edge
// after reset the height memory is cleared, entry by entry, with in_stall high
// a finished rectangle sits in the output register; a draw word completing
// while that register is still stalled waits for it
// ----------------------------------------------------------------------------
module spectrum_bar_updater #(
  parameter int NUM_BINS = sbu_pkg::NUM_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [sbu_pkg::BIN_W-1:0]   bin_index,
  input  logic [sbu_pkg::PWR_W-1:0]   power_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sbu_pkg::DIM_W-1:0]   rect_x_start,
  output logic [sbu_pkg::DIM_W-1:0]   rect_x_end,
  output logic [sbu_pkg::DIM_W-1:0]   rect_y_start,
  output logic [sbu_pkg::DIM_W-1:0]   rect_y_end,
  output logic [sbu_pkg::COL_W-1:0]   fill_color
);
  import sbu_pkg::*;

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [AW-1:0] CLR_END = AW'(NUM_BINS - 1);

  state_t state, state_next;

  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic [PWR_W-1:0] running_max;

  logic [PWR_W-1:0] pwr_mem [NUM_BINS];
  logic [DIM_W-1:0] hgt_mem [NUM_BINS];
  logic [PWR_W-1:0] pwr_rd;
  logic [DIM_W-1:0] hgt_rd;

  logic [AW-1:0]    clr_cnt;
  logic [AW-1:0]    bin_reg;
  logic [AW-1:0]    addr;

  logic accept;
  logic in_range;
  logic start;
  logic emit;
  logic out_free;
  logic cfg_we;

  arith_res_t res;

  logic             grow;
  logic [DIM_W-1:0] top_new;
  logic [DIM_W-1:0] top_old;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_HEIGHT) ? 32'(screen_height) : 32'(screen_width);

  assign addr     = AW'(bin_index);
  assign in_range = (32'(bin_index) < NUM_BINS);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SW_RESET;
      screen_height <= SH_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_WIDTH) screen_width <= pwdata[DIM_W-1:0];
      else                       screen_height <= pwdata[DIM_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    start      = 1'b0;
    emit       = 1'b0;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == CLR_END) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_range && opcode == OP_DRAW) begin
          start      = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (res.done) state_next = res.cut ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      running_max <= PWR_W'(1);
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (accept && in_range && opcode == OP_LOAD) begin
        if (addr == '0)
          running_max <= (power_value > PWR_W'(1)) ? power_value : PWR_W'(1);
        else if (power_value > running_max)
          running_max <= power_value;
      end
      if (emit)          out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // power store
  always_ff @(posedge clk) begin
    if (accept && in_range && opcode == OP_LOAD) pwr_mem[addr] <= power_value;
    if (accept) pwr_rd <= pwr_mem[addr];
  end

  // remembered bar heights
  always_ff @(posedge clk) begin
    if (state == S_CLEAR)  hgt_mem[clr_cnt] <= '0;
    else if (emit)         hgt_mem[bin_reg] <= res.bh;
    if (accept) hgt_rd <= hgt_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (accept) bin_reg <= addr;
  end

  // bin held from the accepted word, the input port already shows the next one
  sbu_arith #(
    .NUM_BINS (NUM_BINS)
  ) u_arith (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .bin  (BIN_W'(bin_reg)),
    .pw   (pwr_rd),
    .pmax (running_max),
    .hgt  (screen_height),
    .swid (screen_width),
    .res  (res)
  );

  assign grow    = (res.bh > hgt_rd);
  assign top_new = (screen_height > res.bh) ? screen_height - res.bh : '0;
  assign top_old = (screen_height > hgt_rd) ? screen_height - hgt_rd : '0;

  always_ff @(posedge clk) begin
    if (emit) begin
      rect_x_start <= res.xs;
      rect_x_end   <= res.xe;
      rect_y_start <= grow ? top_new : top_old;
      rect_y_end   <= grow ? top_old : top_new;
      fill_color   <= grow ? COLOR_WHITE : COLOR_BLACK;
    end
  end

endmodule

### dv/spectrum_bar_updater_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrum_bar_updater_tb
// self-checking bench for the spectrum bar updater. a short table of load and
// draw words goes first, with the obvious rectangles typed in. framed random
// traffic follows, checked against an in-bench scoreboard model of the bar
// heights, over a sweep of screen sizes set through the register port.
// both handshakes idle and stall at random, and long receiver hold-offs, one
// of them forced, back the block up into its input
// ----------------------------------------------------------------------------
module spectrum_bar_updater_tb;
  import sbu_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_WORDS = 90;
  localparam int N_DIRECTED = 25;
  localparam int N_CFG = 7;

  typedef struct packed {
    logic [DIM_W-1:0] xs;
    logic [DIM_W-1:0] xe;
    logic [DIM_W-1:0] ys;
    logic [DIM_W-1:0] ye;
    logic [COL_W-1:0] color;
  } rect_t;

  typedef struct packed {
    logic             op;
    logic [BIN_W-1:0] bin;
    logic [PWR_W-1:0] pwr;
    logic             typed;
    rect_t            rect;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_LOAD;
  logic [BIN_W-1:0] bin_index = '0;
  logic [PWR_W-1:0] power_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DIM_W-1:0] rect_x_start;
  logic [DIM_W-1:0] rect_x_end;
  logic [DIM_W-1:0] rect_y_start;
  logic [DIM_W-1:0] rect_y_end;
  logic [COL_W-1:0] fill_color;

  spectrum_bar_updater dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .bin_index(bin_index), .power_value(power_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .rect_x_start(rect_x_start), .rect_x_end(rect_x_end),
    .rect_y_start(rect_y_start), .rect_y_end(rect_y_end),
    .fill_color(fill_color)
  );

  // scoreboard model state
  logic [PWR_W-1:0] bin_power [NUM_BINS_DEF];
  logic [DIM_W-1:0] bar_height [NUM_BINS_DEF];
  bit bin_loaded [NUM_BINS_DEF];
  logic [BIN_W-1:0] loaded_bins [$];
  logic [PWR_W-1:0] peak_power;
  logic [DIM_W-1:0] cur_width;
  logic [DIM_W-1:0] cur_height;

  rect_t expected_rects [$];
  int mismatches = 0;
  int words_sent = 0;
  int rects_seen = 0;
  int cycle_count = 0;
  int send_mode = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_LOAD, 10'd0, 32'd0, 1'b0, '0},
    '{OP_DRAW, 10'd0, 32'd0, 1'b1, '{12'd0, 12'd1, 12'd480, 12'd480, COLOR_BLACK}},
    '{OP_LOAD, 10'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_DRAW, 10'd0, 32'd0, 1'b1, '{12'd0, 12'd1, 12'd0, 12'd480, COLOR_WHITE}},
    '{OP_LOAD, 10'd1, 32'h8000_0000, 1'b0, '0},
    '{OP_DRAW, 10'd1, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_LOAD, 10'd0, 32'd1, 1'b0, '0},
    '{OP_DRAW, 10'd1, 32'd0, 1'b0, '0},
    '{OP_DRAW, 10'd0, 32'd0, 1'b1, '{12'd0, 12'd1, 12'd0, 12'd0, COLOR_BLACK}},
    '{OP_LOAD, 10'd1023, 32'd5, 1'b0, '0},
    '{OP_LOAD, 10'd638, 32'd7, 1'b0, '0},
    '{OP_LOAD, 10'd639, 32'd3, 1'b0, '0},
    '{OP_DRAW, 10'd1023, 32'd0, 1'b0, '0},
    '{OP_DRAW, 10'd638, 32'd0, 1'b0, '0},
    '{OP_DRAW, 10'd639, 32'd0, 1'b0, '0},
    '{OP_LOAD, 10'd0, 32'd0, 1'b0, '0},
    '{OP_LOAD, 10'd2, 32'd0, 1'b0, '0},
    '{OP_DRAW, 10'd2, 32'd0, 1'b1, '{12'd2, 12'd3, 12'd480, 12'd480, COLOR_BLACK}},
    '{OP_DRAW, 10'd0, 32'd0, 1'b1, '{12'd0, 12'd1, 12'd0, 12'd480, COLOR_BLACK}},
    '{OP_LOAD, 10'd512, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_DRAW, 10'd512, 32'd0, 1'b1, '{12'd512, 12'd513, 12'd0, 12'd480, COLOR_WHITE}},
    '{OP_DRAW, 10'd1, 32'd0, 1'b0, '0},
    '{OP_LOAD, 10'd341, 32'h5555_5555, 1'b0, '0},
    '{OP_LOAD, 10'd682, 32'hAAAA_AAAA, 1'b0, '0},
    '{OP_DRAW, 10'd341, 32'd0, 1'b0, '0}
  };

  logic [DIM_W-1:0] cfg_widths [N_CFG] = '{12'd4095, 12'd300, 12'd1, 12'd2048, 12'd0,
                                           12'd1500, 12'd0};
  logic [DIM_W-1:0] cfg_heights [N_CFG] = '{12'd4095, 12'd17, 12'd1, 12'd100, 12'd2000,
                                            12'd0, 12'd0};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [DIM_W-1:0] sat_diff(logic [DIM_W-1:0] a, logic [DIM_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // applies one word to the model, returns 1 when it yields a rectangle
  function automatic bit render_word(logic op, logic [BIN_W-1:0] bin, logic [PWR_W-1:0] pwr,
                                     output rect_t rect);
    logic [63:0] bw, xs, xe, bh;
    logic [DIM_W-1:0] last, nh;
    rect = '0;
    if (op == OP_LOAD) begin
      bin_power[bin] = pwr;
      if (!bin_loaded[bin]) begin
        bin_loaded[bin] = 1'b1;
        loaded_bins.push_back(bin);
      end
      if (bin == '0) peak_power = (pwr > 1) ? pwr : 32'd1;
      else if (pwr > peak_power) peak_power = pwr;
      return 1'b0;
    end
    bw = 64'(cur_width) / NUM_BINS_DEF;
    if (bw == 0) bw = 1;
    xs = 64'(bin) * bw;
    xe = (64'(bin) + 1) * bw;
    if (xe >= 64'(cur_width)) return 1'b0;
    bh = (64'(bin_power[bin]) * 64'(cur_height)) / 64'(peak_power);
    if (bh > 64'(cur_height)) bh = 64'(cur_height);
    nh = bh[DIM_W-1:0];
    last = bar_height[bin];
    if (nh > last) begin
      rect.ys = sat_diff(cur_height, nh);
      rect.ye = sat_diff(cur_height, last);
      rect.color = COLOR_WHITE;
    end else begin
      rect.ys = sat_diff(cur_height, last);
      rect.ye = sat_diff(cur_height, nh);
      rect.color = COLOR_BLACK;
    end
    bar_height[bin] = nh;
    rect.xs = xs[DIM_W-1:0];
    rect.xe = xe[DIM_W-1:0];
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    case (send_mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      default: return ($urandom_range(0, 24) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 2);
    endcase
  endfunction

  function automatic logic [PWR_W-1:0] rand_power();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 1000);
      3: return $urandom_range(0, 65535) << $urandom_range(0, 16);
      default: return $urandom();
    endcase
  endfunction

  // mostly low bins, some anywhere, some around the right-hand cutoff
  function automatic logic [BIN_W-1:0] pick_bin();
    int bw, b;
    case ($urandom_range(0, 3))
      0, 1: return BIN_W'($urandom_range(0, 15));
      2: return BIN_W'($urandom_range(0, NUM_BINS_DEF - 1));
      default: begin
        bw = cur_width / NUM_BINS_DEF;
        if (bw == 0) bw = 1;
        b = cur_width / bw - $urandom_range(0, 2);
        if (b < 0) b = 0;
        if (b > NUM_BINS_DEF - 1) b = $urandom_range(NUM_BINS_DEF - 24, NUM_BINS_DEF - 1);
        return b[BIN_W-1:0];
      end
    endcase
  endfunction

  task automatic send_word(input logic op, input logic [BIN_W-1:0] bin,
                           input logic [PWR_W-1:0] pwr, input logic typed = 1'b0,
                           input rect_t typed_rect = '0);
    int gap;
    rect_t rect;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    bin_index <= bin;
    power_value <= pwr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (render_word(op, bin, pwr, rect)) expected_rects.push_back(typed ? typed_rect : rect);
    words_sent++;
    if (words_sent % 40 == 0) send_mode = $urandom_range(0, 2);
  endtask

  // register write then read-back, while the block is idle
  task automatic cfg_set(input logic idx, input logic [DIM_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {20'($urandom_range(0, 20'hFFFFF)), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_WIDTH) cur_width = val;
    else cur_height = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {20'd0, val}) begin
      $display("%0t register %0d read-back mismatch: expected %0d, actual %0d",
               $time, idx, val, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int quota);
    int first, choice, k, j, pick;
    logic [BIN_W-1:0] b, tmp;
    logic [BIN_W-1:0] draw_list [$];
    first = words_sent;
    while (words_sent - first < quota) begin
      choice = $urandom_range(0, 9);
      if (choice <= 6 || choice == 9) begin
        // a frame: restart the peak, load some bins, redraw them in any order;
        // a broken frame skips the restart and draws only half
        draw_list.delete();
        if (choice != 9) send_word(OP_LOAD, '0, rand_power());
        k = $urandom_range(1, 8);
        for (j = 0; j < k; j++) begin
          b = pick_bin();
          send_word(OP_LOAD, b, rand_power());
          draw_list.push_back(b);
        end
        k = $urandom_range(0, 3);
        for (j = 0; j < k; j++)
          draw_list.push_back(loaded_bins[$urandom_range(0, loaded_bins.size() - 1)]);
        for (j = draw_list.size() - 1; j > 0; j--) begin
          pick = $urandom_range(0, j);
          tmp = draw_list[j];
          draw_list[j] = draw_list[pick];
          draw_list[pick] = tmp;
        end
        k = (choice == 9) ? draw_list.size() / 2 : draw_list.size();
        for (j = 0; j < k; j++) send_word(OP_DRAW, draw_list[j], $urandom());
      end else if (choice == 7) begin
        send_word(OP_LOAD, pick_bin(), rand_power());
      end else begin
        send_word(OP_DRAW, loaded_bins[$urandom_range(0, loaded_bins.size() - 1)], $urandom());
      end
    end
  endtask

  task automatic check_field(input string name, input logic [DIM_W-1:0] want,
                             input logic [DIM_W-1:0] got);
    if (got !== want) begin
      $display("%0t rect %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // rectangle sink: random stall, plus long hold-offs (one forced) to back the block up
  always @(posedge clk) begin : rect_sink
    rect_t want;
    int recv_mode, burst_left, hold_left;
    bit pressure_done;
    if (rst) begin
      out_stall <= 1'b0;
      recv_mode = 0;
      burst_left = 0;
      hold_left = 0;
      pressure_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        rects_seen++;
        if (expected_rects.size() == 0) begin
          $display("%0t unexpected rect: x %0d..%0d y %0d..%0d colour %0d", $time,
                   rect_x_start, rect_x_end, rect_y_start, rect_y_end, fill_color);
          mismatches++;
        end else begin
          want = expected_rects.pop_front();
          check_field("x_start", want.xs, rect_x_start);
          check_field("x_end", want.xe, rect_x_end);
          check_field("y_start", want.ys, rect_y_start);
          check_field("y_end", want.ye, rect_y_end);
          check_field("colour", 12'(want.color), 12'(fill_color));
        end
      end
      if (cycle_count % 64 == 0) recv_mode = $urandom_range(0, 2);
      if (rects_seen == 40 && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = 400;
      end else if (hold_left == 0 && $urandom_range(0, 2999) == 0) begin
        hold_left = $urandom_range(100, 300);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else begin
        case (recv_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: begin
            if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 60);
            out_stall <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d rects outstanding", $time, expected_rects.size());
      $display("spectrum_bar_updater regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    for (i = 0; i < NUM_BINS_DEF; i++) begin
      bin_power[i] = '0;
      bar_height[i] = '0;
      bin_loaded[i] = 1'b0;
    end
    peak_power = 32'd1;
    cur_width = SW_RESET;
    cur_height = SH_RESET;
    cfg_widths[N_CFG-1] = DIM_W'($urandom_range(1, 4095));
    cfg_heights[N_CFG-1] = DIM_W'($urandom_range(1, 4095));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < N_DIRECTED; i++)
      send_word(directed_rows[i].op, directed_rows[i].bin, directed_rows[i].pwr,
                directed_rows[i].typed, directed_rows[i].rect);
    run_phase(PHASE_WORDS);
    for (i = 0; i < N_CFG; i++) begin
      drain();
      cfg_set(REG_WIDTH, cfg_widths[i]);
      cfg_set(REG_HEIGHT, cfg_heights[i]);
      run_phase(PHASE_WORDS);
    end
    drain();
    if (mismatches == 0) begin
      $display("spectrum_bar_updater regression: pass");
    end else begin
      $display("spectrum_bar_updater regression: fail");
    end
    $finish;
  end

endmodule
